[rtl/a2i_pkg.sv]
// Package for the ARGB to I420 converter: register codes, reset values,
// the item passed from front to back, and the BT.601 colour-space functions.
// No dependencies.
package a2i_pkg;

  localparam int unsigned MaxWidthDef  = 4096;
  localparam int unsigned MaxHeightDef = 4096;

  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  localparam logic [CfgDataW-1:0] FrameWidthRst  = 13'd640;
  localparam logic [CfgDataW-1:0] FrameHeightRst = 13'd480;

  localparam int unsigned ChanSumW   = 9;
  localparam int unsigned LineSumW   = 3 * ChanSumW;
  localparam int unsigned QueueDepth = 2;

  localparam logic [15:0] YCoefR   = 16'd66;
  localparam logic [15:0] YCoefG   = 16'd129;
  localparam logic [15:0] YCoefB   = 16'd25;
  localparam logic [15:0] YOffset  = 16'h1080;
  localparam logic [15:0] CCoefMax = 16'd112;
  localparam logic [15:0] UCoefG   = 16'd74;
  localparam logic [15:0] UCoefR   = 16'd38;
  localparam logic [15:0] VCoefG   = 16'd94;
  localparam logic [15:0] VCoefB   = 16'd18;
  localparam logic [15:0] COffset  = 16'h8080;

  typedef struct packed {
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic                chroma;
    logic                use_line;
    logic                pair;
    logic [ChanSumW-1:0] sum_r;
    logic [ChanSumW-1:0] sum_g;
    logic [ChanSumW-1:0] sum_b;
    logic [LineSumW-1:0] line_sum;
    logic                frame_end;
  } a2i_item_t;

  // last index of a dimension: 0 acts as 1, anything above maxv as maxv
  function automatic int unsigned last_index(logic [CfgDataW-1:0] v, int unsigned maxv);
    int unsigned vi;
    vi = int'(v);
    if (vi == 0) return 0;
    if (vi > maxv) return maxv - 1;
    return vi - 1;
  endfunction

  function automatic logic [7:0] calc_y(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [15:0] acc;
    acc = YCoefR * {8'h00, r} + YCoefG * {8'h00, g} + YCoefB * {8'h00, b} + YOffset;
    return acc[15:8];
  endfunction

  function automatic logic [7:0] calc_u(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [15:0] acc;
    acc = CCoefMax * {8'h00, b} + COffset - UCoefG * {8'h00, g} - UCoefR * {8'h00, r};
    return acc[15:8];
  endfunction

  function automatic logic [7:0] calc_v(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [15:0] acc;
    acc = CCoefMax * {8'h00, r} + COffset - VCoefG * {8'h00, g} - VCoefB * {8'h00, b};
    return acc[15:8];
  endfunction

endpackage

[rtl/a2i_pix_if.sv]
// Pixel input channel: valid/ready handshake with one ARGB pixel a beat.
// No dependencies.
interface a2i_pix_if;
  logic        valid;
  logic        ready;
  logic [31:0] argb_pixel;

  modport source (output valid, output argb_pixel, input ready);
  modport sink   (input valid, input argb_pixel, output ready);
endinterface

[rtl/a2i_res_if.sv]
// Result channel: valid/ready handshake with luma, chroma and frame end a beat.
// No dependencies.
interface a2i_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       chroma_valid;
  logic [7:0] chroma_u;
  logic [7:0] chroma_v;
  logic       frame_end;

  modport source (output valid, output luma, output chroma_valid, output chroma_u,
                  output chroma_v, output frame_end, input ready);
  modport sink   (input valid, input luma, input chroma_valid, input chroma_u,
                  input chroma_v, input frame_end, output ready);
endinterface

[rtl/a2i_front.sv]
// Front part: accepts pixels, tracks column and row, forms pair sums and
// owns the line buffer of first-row pair sums. Depends on a2i_pkg, a2i_pix_if.
module a2i_front
  import a2i_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  a2i_pix_if.sink             pix_i,
  output a2i_item_t           item_o,
  output logic                item_valid_o,
  input  logic                item_ready_i
);

  localparam int unsigned ColW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned LineDepth = (MAX_WIDTH + 1) / 2;
  localparam int unsigned LineAw    = (LineDepth > 1) ? $clog2(LineDepth) : 1;

  logic [ColW-1:0]     col_last_q, col_q, col_d;
  logic [RowW-1:0]     row_last_q, row_q, row_d;
  logic [23:0]         pend_q;
  logic                s1_valid_q;
  a2i_item_t           s1_q, s1_d;
  logic [LineSumW-1:0] rd_q;
  logic [LineSumW-1:0] line_mem [LineDepth];

  logic                accept, last_col, last_row, odd_x, odd_y, pair_end;
  logic                wr_en, rd_en, pend_en;
  logic [7:0]          red, green, blue;
  logic [ChanSumW-1:0] sum_r, sum_g, sum_b;
  logic [LineAw-1:0]   slot;

  assign pix_i.ready = !s1_valid_q || item_ready_i;
  assign accept      = pix_i.valid && pix_i.ready;

  assign red   = pix_i.argb_pixel[23:16];
  assign green = pix_i.argb_pixel[15:8];
  assign blue  = pix_i.argb_pixel[7:0];

  assign last_col = col_q >= col_last_q;
  assign last_row = row_q >= row_last_q;
  assign odd_x    = col_q[0];
  assign odd_y    = row_q[0];
  assign pair_end = odd_x || last_col;
  assign slot     = LineAw'(col_q >> 1);

  always_comb begin
    if (odd_x) begin
      sum_r = {1'b0, red}   + {1'b0, pend_q[23:16]};
      sum_g = {1'b0, green} + {1'b0, pend_q[15:8]};
      sum_b = {1'b0, blue}  + {1'b0, pend_q[7:0]};
    end else begin
      sum_r = {1'b0, red};
      sum_g = {1'b0, green};
      sum_b = {1'b0, blue};
    end
  end

  assign pend_en = accept && !odd_x && !last_col;
  assign wr_en   = accept && pair_end && !odd_y && !last_row;
  assign rd_en   = accept && pair_end && odd_y;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_comb begin
    s1_d           = s1_q;
    s1_d.red       = red;
    s1_d.green     = green;
    s1_d.blue      = blue;
    s1_d.chroma    = pair_end && (odd_y || last_row);
    s1_d.use_line  = odd_y;
    s1_d.pair      = odd_x;
    s1_d.sum_r     = sum_r;
    s1_d.sum_g     = sum_g;
    s1_d.sum_b     = sum_b;
    s1_d.frame_end = last_col && last_row;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= ColW'(last_index(FrameWidthRst, MAX_WIDTH));
      row_last_q <= RowW'(last_index(FrameHeightRst, MAX_HEIGHT));
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_FRAME_WIDTH) begin
        col_last_q <= ColW'(last_index(cfg_data_i, MAX_WIDTH));
      end
      if (cfg_idx_i == REG_FRAME_HEIGHT) begin
        row_last_q <= RowW'(last_index(cfg_data_i, MAX_HEIGHT));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      pend_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (pend_en) begin
        pend_q <= pix_i.argb_pixel[23:0];
      end
      if (pix_i.ready) begin
        s1_valid_q <= pix_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  // line buffer: one write or one read a beat, read data registered
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[slot] <= {sum_r, sum_g, sum_b};
    end
    if (rd_en) begin
      rd_q <= line_mem[slot];
    end
  end

  always_comb begin
    item_o          = s1_q;
    item_o.line_sum = rd_q;
  end

  assign item_valid_o = s1_valid_q;

endmodule

[rtl/a2i_queue.sv]
// Two-entry queue decoupling the front and back parts.
// Depends on a2i_pkg.
module a2i_queue
  import a2i_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  a2i_item_t push_item_i,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  output a2i_item_t pop_item_o,
  output logic      pop_valid_o,
  input  logic      pop_ready_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  a2i_item_t       store_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = cnt_q != CntW'(QueueDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = store_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[rtl/a2i_back.sv]
// Back part: block averages, BT.601 luma and chroma, and the output register.
// Depends on a2i_pkg, a2i_res_if.
module a2i_back
  import a2i_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  a2i_item_t item_i,
  input  logic      item_valid_i,
  output logic      item_ready_o,
  a2i_res_if.source res_o
);

  logic       out_valid_q;
  logic [7:0] luma_q, u_q, v_q;
  logic       cval_q, fend_q;
  logic       load;
  logic [9:0] tot_r, tot_g, tot_b;
  logic [7:0] avg_r, avg_g, avg_b;

  assign item_ready_o = !out_valid_q || res_o.ready;
  assign load         = item_valid_i && item_ready_o;

  always_comb begin
    if (item_i.use_line) begin
      tot_r = {1'b0, item_i.sum_r} + {1'b0, item_i.line_sum[26:18]};
      tot_g = {1'b0, item_i.sum_g} + {1'b0, item_i.line_sum[17:9]};
      tot_b = {1'b0, item_i.sum_b} + {1'b0, item_i.line_sum[8:0]};
    end else begin
      tot_r = {item_i.sum_r, 1'b0};
      tot_g = {item_i.sum_g, 1'b0};
      tot_b = {item_i.sum_b, 1'b0};
    end
    avg_r = item_i.pair ? tot_r[9:2] : tot_r[8:1];
    avg_g = item_i.pair ? tot_g[9:2] : tot_g[8:1];
    avg_b = item_i.pair ? tot_b[9:2] : tot_b[8:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (item_ready_o) begin
      out_valid_q <= item_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      luma_q <= calc_y(item_i.red, item_i.green, item_i.blue);
      cval_q <= item_i.chroma;
      u_q    <= item_i.chroma ? calc_u(avg_r, avg_g, avg_b) : 8'h00;
      v_q    <= item_i.chroma ? calc_v(avg_r, avg_g, avg_b) : 8'h00;
      fend_q <= item_i.frame_end;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.luma         = luma_q;
  assign res_o.chroma_valid = cval_q;
  assign res_o.chroma_u     = u_q;
  assign res_o.chroma_v     = v_q;
  assign res_o.frame_end    = fend_q;

endmodule

[rtl/argb_to_i420_converter.sv]
// ARGB to I420 converter top level: front, queue and back parts.
// Depends on a2i_pkg, a2i_pix_if, a2i_res_if, a2i_front, a2i_queue, a2i_back.
//
// Usage:
//   pix_i carries one ARGB pixel a beat in raster order; alpha is ignored.
//   res_o carries one beat per pixel: its luma, and on the second row of each
//   row pair or lone last row, at every second column (and the last) a U/V
//   sample with chroma_valid set. frame_end marks the last pixel of the frame.
//   frame_width and frame_height are written through cfg_we_i / cfg_idx_i /
//   cfg_data_i while no pixel is in flight; 0 acts as 1, values above
//   MAX_WIDTH / MAX_HEIGHT act as the maximum.
// Timing:
//   One pixel per cycle sustained while res_o is ready. A result passes the
//   front register (line buffer read), the queue and the output register.
// Reset:
//   Counters and handshake state clear; dimensions return to 640 x 480. The
//   line buffer is not cleared: a second row reads only what its first row
//   wrote.
// Back-pressure:
//   A stalled res_o holds its beat; the two-entry queue and the front
//   register absorb up to three more pixels before pix_i.ready drops.
module argb_to_i420_converter
  import a2i_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  a2i_pix_if.sink             pix_i,
  a2i_res_if.source           res_o
);

  a2i_item_t front_item, back_item;
  logic      front_valid, front_ready, back_valid, back_ready;

  a2i_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (pix_i),
    .item_o      (front_item),
    .item_valid_o(front_valid),
    .item_ready_i(front_ready)
  );

  a2i_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_item_i (front_item),
    .push_valid_i(front_valid),
    .push_ready_o(front_ready),
    .pop_item_o  (back_item),
    .pop_valid_o (back_valid),
    .pop_ready_i (back_ready)
  );

  a2i_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (back_item),
    .item_valid_i(back_valid),
    .item_ready_o(back_ready),
    .res_o       (res_o)
  );

endmodule

[tb/argb_to_i420_converter_test.sv]
// Self-checking test of argb_to_i420_converter: pixel frames go in, luma, chroma and
// frame end are predicted per beat and checked in order, with random gaps on both sides.
// Depends on a2i_pkg, a2i_pix_if, a2i_res_if and the converter RTL.
module argb_to_i420_converter_test;
  import a2i_pkg::*;

  localparam int LineDepth = (MaxWidthDef + 1) / 2;
  localparam int RandomItems = 850;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       frame_end;
  } yuv_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  a2i_pix_if pix_bus ();
  a2i_res_if res_bus ();

  argb_to_i420_converter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix_bus),
    .res_o      (res_bus)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the converter state
  logic [CfgDataW-1:0] width_reg  = FrameWidthRst;
  logic [CfgDataW-1:0] height_reg = FrameHeightRst;
  logic [23:0]         left_rgb   = '0;
  logic [11:0]         col_idx    = '0;
  logic [11:0]         row_idx    = '0;
  logic [LineSumW-1:0] first_row_sums [LineDepth];

  yuv_beat_t pending_yuv [$];
  int        error_count = 0;
  int        items_sent  = 0;
  bit        no_idle     = 1'b0;

  function automatic int active_dim(logic [CfgDataW-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return int'(v);
  endfunction

  function automatic logic [7:0] bt601_luma(int r, int g, int b);
    return 8'((66 * r + 129 * g + 25 * b + 'h1080) >> 8);
  endfunction

  function automatic logic [7:0] bt601_cb(int r, int g, int b);
    return 8'((112 * b + 'h8080 - 74 * g - 38 * r) >> 8);
  endfunction

  function automatic logic [7:0] bt601_cr(int r, int g, int b);
    return 8'((112 * r + 'h8080 - 94 * g - 18 * b) >> 8);
  endfunction

  task automatic predict_yuv(input logic [31:0] px, output yuv_beat_t beat);
    int w, h, sr, sg, sb, tr, tg, tb, sh, slot;
    bit last_col, last_row;
    logic [LineSumW-1:0] held;
    w = active_dim(width_reg, MaxWidthDef);
    h = active_dim(height_reg, MaxHeightDef);
    last_col = (int'(col_idx) + 1) >= w;
    last_row = (int'(row_idx) + 1) >= h;
    slot = int'(col_idx >> 1) % LineDepth;
    beat = '0;
    beat.luma = bt601_luma(int'(px[23:16]), int'(px[15:8]), int'(px[7:0]));
    beat.frame_end = last_col && last_row;
    if (!col_idx[0] && !last_col) begin
      left_rgb = px[23:0];
    end else begin
      sr = int'(px[23:16]);
      sg = int'(px[15:8]);
      sb = int'(px[7:0]);
      sh = 1;
      if (col_idx[0]) begin
        sr += int'(left_rgb[23:16]);
        sg += int'(left_rgb[15:8]);
        sb += int'(left_rgb[7:0]);
        sh = 2;
      end
      if (row_idx[0] || last_row) begin
        if (row_idx[0]) begin
          held = first_row_sums[slot];
          tr = sr + int'(held[26:18]);
          tg = sg + int'(held[17:9]);
          tb = sb + int'(held[8:0]);
        end else begin
          // lone last row: block is the row averaged with itself
          tr = 2 * sr;
          tg = 2 * sg;
          tb = 2 * sb;
        end
        tr = (tr >> sh) & 255;
        tg = (tg >> sh) & 255;
        tb = (tb >> sh) & 255;
        beat.chroma_valid = 1'b1;
        beat.chroma_u = bt601_cb(tr, tg, tb);
        beat.chroma_v = bt601_cr(tr, tg, tb);
      end else begin
        first_row_sums[slot] = {9'(sr), 9'(sg), 9'(sb)};
      end
    end
    if (last_col) begin
      col_idx = '0;
      row_idx = last_row ? 12'd0 : row_idx + 12'd1;
    end else begin
      col_idx = col_idx + 12'd1;
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_argb();
    logic [31:0] p;
    p = $urandom();
    if ($urandom_range(0, 3) == 0) begin
      for (int c = 0; c < 3; c++) begin
        if ($urandom_range(0, 1) == 1) p[8*c +: 8] = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      end
    end
    return p;
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  task automatic send_pixel(input logic [31:0] px, output logic fe);
    int gap;
    yuv_beat_t beat;
    gap = pick_gap();
    if (gap > 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_bus.valid <= 1'b1;
    pix_bus.argb_pixel <= px;
    do @(posedge clk_i); while (!pix_bus.ready);
    predict_yuv(px, beat);
    pending_yuv.push_back(beat);
    items_sent++;
    fe = beat.frame_end;
  endtask

  task automatic send_random_frame();
    logic fe;
    do send_pixel(random_argb(), fe); while (!fe);
  endtask

  task automatic wait_idle();
    pix_bus.valid <= 1'b0;
    while (pending_yuv.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      REG_FRAME_WIDTH:  width_reg = val;
      REG_FRAME_HEIGHT: height_reg = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_frame(input logic [CfgDataW-1:0] w, input logic [CfgDataW-1:0] h);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // first row at the reset size, then a shrink while mid-frame
  task automatic test_reset_dimensions();
    logic fe;
    repeat (FrameWidthRst) send_pixel(random_argb(), fe);
    set_frame(13'd4, 13'd1);
    send_random_frame();
  endtask

  task automatic test_colour_extremes();
    logic [31:0] tiles [16] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_0000, 32'hFF00_FF00,
      32'h0000_00FF, 32'h7F80_8080, 32'h00FF_FFFF, 32'hFF00_0000,
      32'h00FF_FFFF, 32'hAAFF_FFFF, 32'h0000_0000, 32'h5500_0000,
      32'hFFFF_FFFF, 32'h00FF_FFFF, 32'hFF00_0000, 32'h0000_0000
    };
    logic fe;
    set_frame(13'd4, 13'd4);
    foreach (tiles[i]) send_pixel(tiles[i], fe);
  endtask

  task automatic test_odd_dimensions();
    set_frame(13'd3, 13'd3);
    send_random_frame();
    set_frame(13'd5, 13'd1);
    send_random_frame();
    set_frame(13'd1, 13'd3);
    send_random_frame();
  endtask

  // shrink the width with the column counter past the new last index
  task automatic test_mid_row_write();
    logic fe;
    set_frame(13'd8, 13'd2);
    repeat (5) send_pixel(random_argb(), fe);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 13'd3);
    send_random_frame();
  endtask

  // zero acts as one; above the maximum the maximum applies, then a shrink ends the frame
  task automatic test_register_clamping();
    logic fe;
    set_frame(13'd0, 13'd0);
    repeat (3) send_random_frame();
    no_idle = 1'b1;
    set_frame(13'h1001, 13'd1);
    repeat (40) send_pixel(random_argb(), fe);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, 13'd2);
    send_random_frame();
    set_frame(13'd2, 13'h1001);
    repeat (20) send_pixel(random_argb(), fe);
    wait_idle();
    write_reg(REG_FRAME_HEIGHT, 13'd1);
    send_random_frame();
    no_idle = 1'b0;
  endtask

  task automatic test_random_frames();
    int start, w, h, sel;
    bit first;
    start = items_sent;
    first = 1'b1;
    while (items_sent - start < RandomItems) begin
      case ($urandom_range(0, 9))
        7, 8:    w = $urandom_range(13, 64);
        9:       w = $urandom_range(65, 300);
        default: w = $urandom_range(0, 12);
      endcase
      h = (w > 64) ? $urandom_range(1, 2) : $urandom_range(0, 7);
      sel = first ? 2 : $urandom_range(0, 2);
      first = 1'b0;
      wait_idle();
      if (sel != 1) write_reg(REG_FRAME_WIDTH, 13'(w));
      if (sel != 0) write_reg(REG_FRAME_HEIGHT, 13'(h));
      no_idle = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(1, 3)) send_random_frame();
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_sink
    yuv_beat_t want;
    int stall_left;
    stall_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_bus.valid && res_bus.ready) begin
        if (pending_yuv.size() == 0) begin
          $display("%0t: beat with nothing predicted, luma %0d", $time, res_bus.luma);
          error_count++;
        end else begin
          want = pending_yuv.pop_front();
          check_field("luma", want.luma, res_bus.luma);
          check_field("chroma_valid", {7'd0, want.chroma_valid}, {7'd0, res_bus.chroma_valid});
          check_field("chroma_u", want.chroma_u, res_bus.chroma_u);
          check_field("chroma_v", want.chroma_v, res_bus.chroma_v);
          check_field("frame_end", {7'd0, want.frame_end}, {7'd0, res_bus.frame_end});
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else begin
        stall_left = pick_gap();
        res_bus.ready <= (stall_left == 0);
      end
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= REG_FRAME_WIDTH;
    cfg_data_i         <= '0;
    pix_bus.valid      <= 1'b0;
    pix_bus.argb_pixel <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_dimensions();
    test_colour_extremes();
    test_odd_dimensions();
    test_mid_row_write();
    test_register_clamping();
    test_random_frames();

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
rtl/a2i_pkg.sv
rtl/a2i_pix_if.sv
rtl/a2i_res_if.sv
rtl/a2i_front.sv
rtl/a2i_queue.sv
rtl/a2i_back.sv
rtl/argb_to_i420_converter.sv
tb/argb_to_i420_converter_test.sv
